// File: hw/rtl/page_framebuffer_dirty_flush_top_assert.svh
// Assertion macros shared by the frame store flush block.
`ifndef PAGE_FRAMEBUFFER_DIRTY_FLUSH_TOP_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DIRTY_FLUSH_TOP_ASSERT_SVH

// Concurrent check on a given clock and active-low reset.
`define PFD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define PFD_ASSERT(label, prop, msg) \
  `PFD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Types and codes shared by the page frame store with dirty-window flush.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam logic [2:0] CMD_OFF   = 3'd0;
  localparam logic [2:0] CMD_ON    = 3'd1;
  localparam logic [2:0] CMD_XOR   = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  localparam logic [7:0] COLUMN_CMD = 8'h80;
  localparam logic [7:0] PAGE_CMD   = 8'h40;

  typedef enum logic [1:0] {
    PH_COLUMN = 2'd0,
    PH_PAGE   = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_INIT  = 2'd0,
    ST_IDLE  = 2'd1,
    ST_CLEAR = 2'd2,
    ST_EXEC  = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] px;
    logic [7:0] py;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       byte_valid;
    logic       flush_last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic exec;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic in_clear;
    logic sweep_last;
  } sts_t;

endpackage

// File: hw/rtl/page_framebuffer_dirty_flush_top.sv
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_flush_top
// Page-organized monochrome frame store with a dirty window and byte flush.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A pixel
// command or a flush step is first accepted, which addresses the store,
// then executed, which does the read-modify-write or takes the flush byte
// from the registered read port of the single store RAM. A clear first
// zeroes the store one byte per cycle through its one write port, then
// executes. After reset the block runs the same clearing pass and stalls
// input until it ends. The result sits in an output register, so the next
// transaction is accepted while a finished result is still waiting to be
// taken.
module page_framebuffer_dirty_flush_top #(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfd_pkg::out_t out_data_o
);

  pfd_pkg::ctl_t ctl;
  pfd_pkg::sts_t sts;

  pfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pfd_dpath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

// File: hw/rtl/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pfd_ctrl.sv
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer: clearing pass, transaction accept, execute and result handoff.
// ----------------------------------------------------------------------------
`include "page_framebuffer_dirty_flush_top_assert.svh"

module pfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  pfd_pkg::sts_t sts_i,
  output pfd_pkg::ctl_t ctl_o
);

  pfd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfd_pkg::ST_INIT: begin
        if (sts_i.sweep_last) begin
          state_d = pfd_pkg::ST_IDLE;
        end
      end
      pfd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_clear ? pfd_pkg::ST_CLEAR : pfd_pkg::ST_EXEC;
        end
      end
      pfd_pkg::ST_CLEAR: begin
        if (sts_i.sweep_last) begin
          state_d = pfd_pkg::ST_EXEC;
        end
      end
      pfd_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = pfd_pkg::ST_IDLE;
        end
      end
      default: state_d = pfd_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    ctl_o.accept = (state_q == pfd_pkg::ST_IDLE) && in_valid_i;
    ctl_o.sweep  = (state_q == pfd_pkg::ST_INIT) || (state_q == pfd_pkg::ST_CLEAR);
    ctl_o.exec   = (state_q == pfd_pkg::ST_EXEC) && out_free;
    in_stall_o   = (state_q != pfd_pkg::ST_IDLE);
    // load on execute, drop once taken
    if (ctl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfd_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PFD_ASSERT(a_accept_busy, ctl_o.accept |=> (state_q != pfd_pkg::ST_IDLE), "accept left idle")
  `PFD_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !ctl_o.exec, "result overwritten")
  `PFD_ASSERT(a_exec_valid, ctl_o.exec |=> out_valid_q, "executed result not presented")
  `PFD_ASSERT(a_init_done, ((state_q == pfd_pkg::ST_INIT) && sts_i.sweep_last) |=>
    (state_q == pfd_pkg::ST_IDLE), "clearing pass did not end in idle")

endmodule

// File: hw/rtl/pfd_dpath.sv
// ----------------------------------------------------------------------------
// pfd_dpath
// Frame store, dirty window marks, flush sequencing and result register.
// ----------------------------------------------------------------------------
module pfd_dpath #(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfd_pkg::in_t  in_data_i,
  input  pfd_pkg::ctl_t ctl_i,
  output pfd_pkg::sts_t sts_o,
  output pfd_pkg::out_t out_data_o
);

  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PG_W       = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
  localparam logic [PG_W-1:0]   LAST_PG   = PG_W'(PAGES - 1);
  localparam logic [7:0]        LAST_COL  = 8'(COLUMNS - 1);

  // accepted transaction
  logic [2:0]        cmd_q;
  logic [7:0]        px_q;
  logic [2:0]        bit_q;
  logic [PG_W-1:0]   pg_q;
  logic [ADDR_W-1:0] addr_q;
  logic              off_q;

  // dirty window; low mark kept both linear and as page/column
  logic [ADDR_W-1:0] low_q, low_d;
  logic [PG_W-1:0]   low_pg_q, low_pg_d;
  logic [7:0]        low_col_q, low_col_d;
  logic [ADDR_W-1:0] high_q, high_d;
  pfd_pkg::phase_e   phase_q, phase_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] clr_q;

  pfd_pkg::out_t out_q, out_d;

  logic [15:0]       idx_full;
  logic              pixel_in, off_in, pixel_q;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [7:0]        rdata, wdata, mask, new_byte;
  logic              we;

  assign pixel_in = (in_data_i.cmd == pfd_pkg::CMD_OFF) || (in_data_i.cmd == pfd_pkg::CMD_ON) ||
                    (in_data_i.cmd == pfd_pkg::CMD_XOR);
  assign pixel_q  = (cmd_q == pfd_pkg::CMD_OFF) || (cmd_q == pfd_pkg::CMD_ON) ||
                    (cmd_q == pfd_pkg::CMD_XOR);
  assign off_in   = ({1'b0, in_data_i.px} >= 9'(COLUMNS)) || ({1'b0, in_data_i.py} >= 9'(ROWS));
  assign idx_full = 16'(in_data_i.py[7:3]) * 16'(COLUMNS) + 16'(in_data_i.px);

  // read the byte the transaction needs, held steady until execute
  always_comb begin
    if (ctl_i.accept) begin
      raddr = pixel_in ? idx_full[ADDR_W-1:0] : pos_q;
    end else begin
      raddr = pixel_q ? addr_q : pos_q;
    end
  end

  assign mask = 8'(1) << bit_q;

  always_comb begin
    unique case (cmd_q)
      pfd_pkg::CMD_OFF: new_byte = rdata & ~mask;
      pfd_pkg::CMD_ON:  new_byte = rdata | mask;
      default:          new_byte = rdata ^ mask;
    endcase
  end

  always_comb begin
    if (ctl_i.sweep) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 8'd0;
    end else begin
      we    = ctl_i.exec && pixel_q && !off_q;
      waddr = addr_q;
      wdata = new_byte;
    end
  end

  pfd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sts_o.in_clear   = (in_data_i.cmd == pfd_pkg::CMD_CLEAR);
  assign sts_o.sweep_last = (clr_q == LAST_ADDR);

  always_comb begin
    low_d     = low_q;
    low_pg_d  = low_pg_q;
    low_col_d = low_col_q;
    high_d    = high_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    out_d     = '0;
    if (pixel_q) begin
      if (off_q) begin
        out_d.status = 1'b1;
      end else begin
        if (addr_q < low_q) begin
          low_d     = addr_q;
          low_pg_d  = pg_q;
          low_col_d = px_q;
        end
        if (addr_q > high_q) begin
          high_d = addr_q;
        end
        phase_d = pfd_pkg::PH_COLUMN;
        pos_d   = '0;
      end
    end else if (cmd_q == pfd_pkg::CMD_CLEAR) begin
      low_d     = '0;
      low_pg_d  = '0;
      low_col_d = '0;
      high_d    = LAST_ADDR;
      phase_d   = pfd_pkg::PH_COLUMN;
      pos_d     = '0;
    end else if (cmd_q == pfd_pkg::CMD_FLUSH) begin
      out_d.byte_valid = 1'b1;
      unique case (phase_q)
        pfd_pkg::PH_COLUMN: begin
          out_d.lcd_byte = pfd_pkg::COLUMN_CMD | low_col_q;
          phase_d        = pfd_pkg::PH_PAGE;
        end
        pfd_pkg::PH_PAGE: begin
          out_d.lcd_byte = pfd_pkg::PAGE_CMD | 8'(low_pg_q);
          if (low_q > high_q) begin
            // empty window: page command closes the sequence
            out_d.flush_last = 1'b1;
            low_d     = LAST_ADDR;
            low_pg_d  = LAST_PG;
            low_col_d = LAST_COL;
            high_d    = '0;
            phase_d   = pfd_pkg::PH_COLUMN;
          end else begin
            pos_d   = low_q;
            phase_d = pfd_pkg::PH_DATA;
          end
        end
        pfd_pkg::PH_DATA: begin
          out_d.lcd_byte = rdata;
          out_d.is_data  = 1'b1;
          if ((pos_q >= high_q) || (pos_q >= LAST_ADDR)) begin
            out_d.flush_last = 1'b1;
            low_d     = LAST_ADDR;
            low_pg_d  = LAST_PG;
            low_col_d = LAST_COL;
            high_d    = '0;
            phase_d   = pfd_pkg::PH_COLUMN;
            pos_d     = '0;
          end else begin
            pos_d = pos_q + ADDR_W'(1);
          end
        end
        default: begin
          phase_d = pfd_pkg::PH_COLUMN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= in_data_i.cmd;
      px_q   <= in_data_i.px;
      bit_q  <= in_data_i.py[2:0];
      pg_q   <= PG_W'(in_data_i.py[7:3]);
      addr_q <= idx_full[ADDR_W-1:0];
      off_q  <= off_in;
    end
    if (ctl_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= LAST_ADDR;
      low_pg_q  <= LAST_PG;
      low_col_q <= LAST_COL;
      high_q    <= '0;
      phase_q   <= pfd_pkg::PH_COLUMN;
      pos_q     <= '0;
      clr_q     <= '0;
    end else begin
      if (ctl_i.exec) begin
        low_q     <= low_d;
        low_pg_q  <= low_pg_d;
        low_col_q <= low_col_d;
        high_q    <= high_d;
        phase_q   <= phase_d;
        pos_q     <= pos_d;
      end
      // wrap to zero so the next sweep starts at the first byte
      if (ctl_i.sweep) begin
        clr_q <= sts_o.sweep_last ? '0 : clr_q + ADDR_W'(1);
      end
    end
  end

  assign out_data_o = out_q;

endmodule
